// File: hdl/dlqc_pkg.sv
// Package for the dual linear queue compare block.
// Holds operation codes, status codes, FSM states and the controller/datapath buses.
// No dependencies.
package dlqc_pkg;

    localparam int WORD_W = 32;

    // Operation codes carried on func
    typedef enum logic [1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_CMP = 2'd2,
        FUNC_NOP = 2'd3
    } func_t;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [WORD_W-1:0] NEG_ONE = '1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_RD,
        S_CMP_RD,
        S_CMP_CHK
    } state_t;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_NONE,
        RES_FULL,
        RES_EMPTY,
        RES_DEQ_DATA,
        RES_SAME,
        RES_DIFF
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic enq;
        logic deq;
        logic rd_en;
        logic off_inc;
        logic off_clr;
        logic load_res;
        res_t res;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty_sel;
        logic full_sel;
        logic empty_a;
        logic empty_b;
        logic counts_eq;
        logic last_elem;
        logic elem_match;
    } stat_t;

endpackage

// File: hdl/dlqc_ctrl.sv
// Controller FSM for the dual linear queue compare block.
// Sequences enqueue, dequeue and the compare walk; owns the output valid flag.
// Depends on dlqc_pkg.
module dlqc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    output logic              out_valid,
    input  logic              out_ready,
    output dlqc_pkg::cmd_t    cmd,
    input  dlqc_pkg::stat_t   stat
);
    import dlqc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    func_t  op;

    assign op        = func_t'(func);
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_NONE;
        cmd.accept = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        FUNC_ENQ:
                        begin
                            cmd.load_res = 1'b1;
                            if (stat.full_sel)
                                cmd.res = RES_FULL;
                            else
                                cmd.enq = 1'b1;
                        end
                        FUNC_DEQ:
                        begin
                            if (stat.empty_sel)
                            begin
                                cmd.load_res = 1'b1;
                                cmd.res      = RES_EMPTY;
                            end
                            else
                            begin
                                cmd.deq    = 1'b1;
                                cmd.rd_en  = 1'b1;
                                state_next = S_DEQ_RD;
                            end
                        end
                        FUNC_CMP:
                        begin
                            if (stat.empty_a && stat.empty_b)
                            begin
                                cmd.load_res = 1'b1;
                                cmd.res      = RES_SAME;
                            end
                            else if (stat.empty_a || stat.empty_b || !stat.counts_eq)
                            begin
                                cmd.load_res = 1'b1;
                                cmd.res      = RES_DIFF;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                state_next = S_CMP_CHK;
                            end
                        end
                        default:
                        begin
                            cmd.load_res = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ_RD:
            begin
                cmd.load_res = 1'b1;
                cmd.res      = RES_DEQ_DATA;
                state_next   = S_IDLE;
            end
            S_CMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (!stat.elem_match)
                begin
                    cmd.load_res = 1'b1;
                    cmd.res      = RES_DIFF;
                    cmd.off_clr  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.last_elem)
                begin
                    cmd.load_res = 1'b1;
                    cmd.res      = RES_SAME;
                    cmd.off_clr  = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.off_inc = 1'b1;
                    state_next  = S_CMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on result load, cleared when the item is taken
    always_comb
    begin
        if (cmd.load_res)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // A result is only loaded into a free or draining output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending item");

    // Every element check follows a read issued the cycle before
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP_CHK) |-> $past(cmd.rd_en))
        else $error("compare check without a preceding read");

    // Dequeue data is loaded in the cycle after the pointer update
    a_deq_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> (state_reg == S_DEQ_RD) && cmd.load_res)
        else $error("dequeue result not loaded after read");

endmodule

// File: hdl/dlqc_datapath.sv
// Datapath for the dual linear queue compare block.
// Two queue stores with head/tail pointers, the compare offset and the result register.
// Depends on dlqc_pkg.
module dlqc_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               queue_sel,
    input  logic signed [dlqc_pkg::WORD_W-1:0] data_in,
    input  dlqc_pkg::cmd_t                     cmd,
    output dlqc_pkg::stat_t                    stat,
    output logic signed [dlqc_pkg::WORD_W-1:0] data_out,
    output logic [1:0]                         status,
    output logic                               queues_differ
);
    import dlqc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Queue stores
    logic [WORD_W-1:0] store_a [DEPTH];
    logic [WORD_W-1:0] store_b [DEPTH];

    // Pointers, index 0 is queue A, 1 is queue B
    logic [AW-1:0] head_reg  [2];
    logic [AW-1:0] head_next [2];
    logic [AW-1:0] tail_reg  [2];
    logic [AW-1:0] tail_next [2];
    logic          empty_reg [2];
    logic          empty_next[2];

    logic [AW-1:0]     off_reg, off_next;
    logic              sel_reg;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic [WORD_W-1:0] rdata_a_reg, rdata_b_reg, rdata_sel;
    logic [WORD_W-1:0] data_out_reg;
    logic [1:0]        status_reg;
    logic              differ_reg;

    // Status toward the controller
    always_comb
    begin
        stat.empty_sel  = empty_reg[queue_sel];
        stat.full_sel   = !empty_reg[queue_sel] && (tail_reg[queue_sel] == LAST_SLOT);
        stat.empty_a    = empty_reg[0];
        stat.empty_b    = empty_reg[1];
        stat.counts_eq  = (tail_reg[0] - head_reg[0]) == (tail_reg[1] - head_reg[1]);
        stat.last_elem  = off_reg == (tail_reg[0] - head_reg[0]);
        stat.elem_match = rdata_a_reg == rdata_b_reg;
    end

    // Pointer update for enqueue and dequeue
    assign wr_addr = empty_reg[queue_sel] ? '0 : tail_reg[queue_sel] + 1'b1;

    always_comb
    begin
        for (int q = 0; q < 2; q++)
        begin
            head_next[q]  = head_reg[q];
            tail_next[q]  = tail_reg[q];
            empty_next[q] = empty_reg[q];
        end
        if (cmd.enq)
        begin
            if (empty_reg[queue_sel])
                head_next[queue_sel] = '0;
            tail_next[queue_sel]  = wr_addr;
            empty_next[queue_sel] = 1'b0;
        end
        else if (cmd.deq)
        begin
            if (head_reg[queue_sel] == tail_reg[queue_sel])
            begin
                empty_next[queue_sel] = 1'b1;
                head_next[queue_sel]  = '0;
                tail_next[queue_sel]  = '0;
            end
            else
                head_next[queue_sel] = head_reg[queue_sel] + 1'b1;
        end
    end

    // Compare offset
    always_comb
    begin
        if (cmd.off_clr)
            off_next = '0;
        else if (cmd.off_inc)
            off_next = off_reg + 1'b1;
        else
            off_next = off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < 2; q++)
            begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                empty_reg[q] <= 1'b1;
            end
            off_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            for (int q = 0; q < 2; q++)
            begin
                head_reg[q]  <= head_next[q];
                tail_reg[q]  <= tail_next[q];
                empty_reg[q] <= empty_next[q];
            end
            off_reg <= off_next;
            if (cmd.accept)
                sel_reg <= queue_sel;
        end
    end

    // Store writes
    always_ff @(posedge clk)
    begin
        if (cmd.enq && !queue_sel)
            store_a[wr_addr] <= data_in;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq && queue_sel)
            store_b[wr_addr] <= data_in;
    end

    // Registered reads at head plus offset (offset is zero for dequeue)
    assign rd_addr_a = head_reg[0] + off_reg;
    assign rd_addr_b = head_reg[1] + off_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_a_reg <= store_a[rd_addr_a];
            rdata_b_reg <= store_b[rd_addr_b];
        end
    end

    assign rdata_sel = sel_reg ? rdata_b_reg : rdata_a_reg;

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            case (cmd.res)
                RES_FULL:
                begin
                    data_out_reg <= '0;
                    status_reg   <= STAT_FULL;
                    differ_reg   <= 1'b0;
                end
                RES_EMPTY:
                begin
                    data_out_reg <= NEG_ONE;
                    status_reg   <= STAT_EMPTY;
                    differ_reg   <= 1'b0;
                end
                RES_DEQ_DATA:
                begin
                    data_out_reg <= rdata_sel;
                    status_reg   <= STAT_OK;
                    differ_reg   <= 1'b0;
                end
                RES_DIFF:
                begin
                    data_out_reg <= '0;
                    status_reg   <= STAT_OK;
                    differ_reg   <= 1'b1;
                end
                default:
                begin
                    data_out_reg <= '0;
                    status_reg   <= STAT_OK;
                    differ_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign data_out      = data_out_reg;
    assign status        = status_reg;
    assign queues_differ = differ_reg;

    // No enqueue into a full queue
    a_no_full_enq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |-> !stat.full_sel)
        else $error("enqueue into full queue");

    // No dequeue from an empty queue
    a_no_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |-> !stat.empty_sel)
        else $error("dequeue from empty queue");

    // The compare walk never steps past the last element
    a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.off_inc |-> !stat.last_elem && !empty_reg[0] && !empty_reg[1])
        else $error("compare offset past last element");

endmodule

// File: hdl/dual_linear_queue_compare_core.sv
// Top level of the dual linear queue compare block.
// Instantiates dlqc_ctrl and dlqc_datapath; depends on dlqc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, queue_sel and data_in.
//   func selects enqueue, dequeue or compare of queues A and B; code 3 does nothing.
//   Output channel (out_valid/out_ready) carries data_out, status and
//   queues_differ, exactly one item per input item, in order.
// Sequencing:
//   Enqueue, full enqueue, empty dequeue, no-op and early-decided compares load
//   the result at the accepting edge, one item per cycle while the output does not stall.
//   A dequeue reads the store through its registered read port.
//   A compare of two equal-length nonempty queues walks element pairs through
//   the same read port, stopping at the first mismatch.
//   No new item is taken during a walk.
// Reset:
//   Both queues are empty after reset; store contents are not cleared.
// Stall:
//   One output register; a new item is taken while the pending result is
//   being taken in the same cycle, otherwise in_ready stays low.
module dual_linear_queue_compare_core #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic                               queue_sel,
    input  logic signed [dlqc_pkg::WORD_W-1:0] data_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [dlqc_pkg::WORD_W-1:0] data_out,
    output logic [1:0]                         status,
    output logic                               queues_differ
);
    import dlqc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    dlqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Queue stores, pointers and result register
    dlqc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_sel     (queue_sel),
        .data_in       (data_in),
        .cmd           (cmd),
        .stat          (stat),
        .data_out      (data_out),
        .status        (status),
        .queues_differ (queues_differ)
    );

endmodule
